// ===== hdl/edfs_pkg.sv =====
package edfs_pkg;

  localparam int NUM_TASKS_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int BUDGET_BITS_DEF = 16;
  localparam int TIME_W          = 32;
  localparam int PERIOD_W        = 16;
  localparam int TASK_W          = 3;
  localparam int CFG_W           = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int NUM_CFG         = 4;

  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] release_t;
    logic [15:0]       remaining;
    logic [TIME_W-1:0] preempt_t;
  } job_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

  // a strictly precedes b in dispatch order
  function automatic logic earlier(input job_t a, input job_t b);
    if (a.deadline != b.deadline) return a.deadline < b.deadline;
    if (a.release_t != b.release_t) return a.release_t < b.release_t;
    return a.task_id < b.task_id;
  endfunction

endpackage

// ===== hdl/edf_periodic_task_scheduler.sv =====
// EDF scheduler for up to four periodic tasks. Each input beat is one tick
// (restart=1 clears all state but the cfg words and releases every enabled
// task at time 0). Each tick gives exactly one output beat. Task periods and
// budgets come from the four cfg words; the user must see that those are
// written only while no tick is in flight; the block does not enforce it.
// The job queue lives in a RAM with one read port, one write port and a
// registered read. A sequencer walks it entry by entry: read, then modify
// and write back. The passes are the retire shift, one miss scan per due
// task, the earliest-deadline search, and the rotate that moves the winner
// to the head.
// The next tick is accepted once the result sits in the output register,
// even while that result still waits to be taken. The following result then
// holds in the done state until the output register frees up.
module edf_periodic_task_scheduler #(
  parameter int NUM_TASKS   = edfs_pkg::NUM_TASKS_DEF,
  parameter int QUEUE_DEPTH = edfs_pkg::QUEUE_DEPTH_DEF,
  parameter int BUDGET_BITS = edfs_pkg::BUDGET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [edfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [edfs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [31:0]                    out_current_time,
  output logic [2:0]                     out_running_task,
  output logic                           out_started,
  output logic [2:0]                     out_preempted_task,
  output logic [2:0]                     out_completed_task,
  output logic [3:0]                     out_missed_mask,
  output logic                           out_queue_full,
  output logic [31:0]                    out_waiting_sum,
  output logic [31:0]                    out_jobs_created
);
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [CW-1:0] QD = CW'(QUEUE_DEPTH);
  localparam logic [15:0] BUD_MASK = 16'((17'd1 << BUDGET_BITS) - 17'd1);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RC_R = 4'd1;   // retire check: read head
  localparam logic [3:0] S_RC_W = 4'd2;   // retire check: decide
  localparam logic [3:0] S_SH_R = 4'd3;   // retire shift: read entry j
  localparam logic [3:0] S_SH_W = 4'd4;   // retire shift: write entry j-1
  localparam logic [3:0] S_TASK = 4'd5;   // per task countdown
  localparam logic [3:0] S_MS_R = 4'd6;   // miss scan read
  localparam logic [3:0] S_MS_W = 4'd7;   // miss scan compare, write back
  localparam logic [3:0] S_REL  = 4'd8;   // release write
  localparam logic [3:0] S_SR_R = 4'd9;   // search read
  localparam logic [3:0] S_SR_W = 4'd10;  // search compare
  localparam logic [3:0] S_DEC  = 4'd11;  // dispatch decision
  localparam logic [3:0] S_RT_R = 4'd12;  // rotate: read entry i-1
  localparam logic [3:0] S_RT_W = 4'd13;  // rotate: write entry i
  localparam logic [3:0] S_HW   = 4'd14;  // write winner at head, run one unit
  localparam logic [3:0] S_DONE = 4'd15;

  logic [edfs_pkg::CFG_W-1:0]    task_word_r [edfs_pkg::NUM_CFG];
  logic [edfs_pkg::PERIOD_W-1:0] cnt_r [NUM_TASKS];
  logic [3:0]     state_r;
  logic [31:0]    time_r, wait_r, created_r;
  logic [CW-1:0]  count_r;
  logic [2:0]     run_r;
  logic [CW-1:0]  idx_r;
  logic [AW-1:0]  best_r;
  logic [TW-1:0]  tsk_r;
  logic           restart_r;
  edfs_pkg::job_t best_job_r;
  logic [2:0]     pre_r, comp_r;
  logic [3:0]     miss_r;
  logic           full_r, start_r;
  logic           ovalid_r;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  edfs_pkg::job_t wdata, rdata;

  logic [edfs_pkg::CFG_W-1:0] cur_word;
  logic [15:0]    per, bud;
  logic [CW-1:0]  idx_inc, idx_dec;
  logic           mis_hit;
  logic           last_task;
  logic           take;
  logic           out_free;

  edfs_job_ram #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < edfs_pkg::NUM_CFG; i++) task_word_r[i] <= '0;
    end else if (cfg_we) begin
      task_word_r[cfg_index] <= cfg_data;
    end
  end

  // period and budget of the task under the sequencer
  assign cur_word  = task_word_r[edfs_pkg::CFG_IDX_W'(tsk_r)];
  assign per       = cur_word[31:16];
  assign bud       = cur_word[15:0] & BUD_MASK;
  assign idx_inc   = idx_r + 1'b1;
  assign idx_dec   = idx_r - 1'b1;
  assign last_task = (tsk_r == TW'(NUM_TASKS - 1));
  assign mis_hit   = (rdata.task_id == 3'(tsk_r) + 3'd1) && (rdata.deadline == time_r);

  assign in_ready = (state_r == S_IDLE);
  assign take     = in_valid && in_ready;
  assign out_free = !ovalid_r || out_ready;

  // RAM address/write mux; every write lands before any read of the same
  // entry, so no forwarding is needed
  always_comb begin
    we = 1'b0; waddr = '0; raddr = '0; wdata = rdata;
    case (state_r)
      S_RC_R: raddr = '0;
      S_SH_R, S_MS_R, S_SR_R: raddr = idx_r[AW-1:0];
      S_SH_W: begin
        we = 1'b1; waddr = idx_dec[AW-1:0];
      end
      S_MS_W: begin
        // missed job: deadline moves one period on
        we = mis_hit; waddr = idx_r[AW-1:0];
        wdata.deadline = time_r + 32'(per);
      end
      S_REL: begin
        we = (count_r < QD); waddr = count_r[AW-1:0];
        wdata.task_id   = 3'(tsk_r) + 3'd1;
        wdata.deadline  = time_r + 32'(per);
        wdata.release_t = time_r;
        wdata.remaining = bud;
        wdata.preempt_t = time_r;
      end
      S_RT_R: raddr = idx_dec[AW-1:0];
      S_RT_W: begin
        we = 1'b1; waddr = idx_r[AW-1:0];
        // preempted old head is stamped as it moves to slot 1
        if (idx_dec == '0 && pre_r != '0) wdata.preempt_t = time_r;
      end
      S_HW: begin
        we = 1'b1; waddr = '0; wdata = best_job_r;
        if (best_job_r.remaining != 16'd0) wdata.remaining = best_job_r.remaining - 16'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; time_r <= '0; wait_r <= '0; created_r <= '0;
      count_r <= '0; run_r <= '0; ovalid_r <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) cnt_r[i] <= '0;
      idx_r <= '0; tsk_r <= '0; best_r <= '0; restart_r <= 1'b0;
      pre_r <= '0; comp_r <= '0; miss_r <= '0; full_r <= 1'b0; start_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;

      case (state_r)
        S_IDLE: if (take) begin
          restart_r <= in_restart;
          pre_r <= '0; comp_r <= '0; miss_r <= '0; full_r <= 1'b0; start_r <= 1'b0;
          tsk_r <= '0; idx_r <= '0;
          if (in_restart) begin
            time_r <= '0; count_r <= '0; run_r <= '0; wait_r <= '0; created_r <= '0;
            for (int i = 0; i < NUM_TASKS; i++) cnt_r[i] <= '0;
            state_r <= S_TASK;
          end else begin
            time_r <= time_r + 32'd1;
            state_r <= S_RC_R;
          end
        end
        S_RC_R: state_r <= S_RC_W;
        S_RC_W: begin
          // running job with its budget used up is retired
          if (run_r != '0 && count_r != '0 && rdata.remaining == 16'd0) begin
            comp_r <= run_r; run_r <= '0;
            if (count_r > CW'(1)) begin
              idx_r <= CW'(1); state_r <= S_SH_R;
            end else begin
              count_r <= count_r - 1'b1; state_r <= S_TASK;
            end
          end else begin
            state_r <= S_TASK;
          end
        end
        S_SH_R: state_r <= S_SH_W;
        S_SH_W: begin
          if (idx_inc < count_r) begin
            idx_r <= idx_inc; state_r <= S_SH_R;
          end else begin
            count_r <= count_r - 1'b1; state_r <= S_TASK;
          end
        end
        S_TASK: begin
          if (per == 16'd0) begin
            // disabled task keeps its countdown
            if (last_task) begin
              idx_r <= '0; state_r <= S_SR_R;
            end else tsk_r <= tsk_r + 1'b1;
          end else if (restart_r) begin
            cnt_r[tsk_r] <= per; state_r <= S_REL;
          end else if (cnt_r[tsk_r] > 16'd1) begin
            cnt_r[tsk_r] <= cnt_r[tsk_r] - 16'd1;
            if (last_task) begin
              idx_r <= '0; state_r <= S_SR_R;
            end else tsk_r <= tsk_r + 1'b1;
          end else begin
            // due: reload, scan for misses, then release
            cnt_r[tsk_r] <= per;
            if (count_r == '0) state_r <= S_REL;
            else begin
              idx_r <= '0; state_r <= S_MS_R;
            end
          end
        end
        S_MS_R: state_r <= S_MS_W;
        S_MS_W: begin
          if (mis_hit) miss_r[tsk_r] <= 1'b1;
          if (idx_inc < count_r) begin
            idx_r <= idx_inc; state_r <= S_MS_R;
          end else state_r <= S_REL;
        end
        S_REL: begin
          if (count_r < QD) begin
            count_r <= count_r + 1'b1;
            created_r <= edfs_pkg::sat_add(created_r, 32'd1);
          end else full_r <= 1'b1;
          if (last_task) begin
            idx_r <= '0; state_r <= S_SR_R;
          end else begin
            tsk_r <= tsk_r + 1'b1; state_r <= S_TASK;
          end
        end
        S_SR_R: begin
          if (count_r == '0) begin
            run_r <= '0; state_r <= S_DONE;
          end else state_r <= S_SR_W;
        end
        S_SR_W: begin
          if (idx_r == '0 || edfs_pkg::earlier(rdata, best_job_r)) begin
            best_job_r <= rdata; best_r <= idx_r[AW-1:0];
          end
          if (idx_inc < count_r) begin
            idx_r <= idx_inc; state_r <= S_SR_R;
          end else state_r <= S_DEC;
        end
        S_DEC: begin
          // new dispatch when idle or when the head loses
          if (run_r == '0 || best_r != '0) begin
            start_r <= 1'b1;
            wait_r <= edfs_pkg::sat_add(wait_r, time_r - best_job_r.preempt_t);
            if (run_r != '0) pre_r <= run_r;
          end
          run_r <= best_job_r.task_id;
          if (best_r != '0) begin
            idx_r <= CW'(best_r); state_r <= S_RT_R;
          end else state_r <= S_HW;
        end
        S_RT_R: state_r <= S_RT_W;
        S_RT_W: begin
          if (idx_r == CW'(1)) state_r <= S_HW;
          else begin
            idx_r <= idx_dec; state_r <= S_RT_R;
          end
        end
        S_HW: state_r <= S_DONE;
        S_DONE: if (out_free) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register: loaded once the previous beat is gone or leaving
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_current_time   <= time_r;
      out_running_task   <= run_r;
      out_started        <= start_r;
      out_preempted_task <= pre_r;
      out_completed_task <= comp_r;
      out_missed_mask    <= miss_r;
      out_queue_full     <= full_r;
      out_waiting_sum    <= wait_r;
      out_jobs_created   <= created_r;
    end
  end
  assign out_valid = ovalid_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_current_time))
    else $error("result beat not held");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QD) else $error("queue count overflow");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !in_ready) else $error("accepted while busy");
endmodule

// ===== hdl/edfs_job_ram.sv =====
module edfs_job_ram #(
  parameter int DEPTH = edfs_pkg::QUEUE_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  edfs_pkg::job_t   wdata,
  input  logic [AW-1:0]    raddr,
  output edfs_pkg::job_t   rdata
);
  edfs_pkg::job_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== tb/sv/edf_periodic_task_scheduler_test.sv =====
module edf_periodic_task_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int TAIL_CYCLES  = 300;
  localparam int SLOTS        = 16;

  // Task register indexes
  typedef enum int {
    TASK_WORD_0 = 0,
    TASK_WORD_1 = 1,
    TASK_WORD_2 = 2,
    TASK_WORD_3 = 3
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] cur_time;
    logic [2:0]  running_task;
    logic        started;
    logic [2:0]  preempted_task;
    logic [2:0]  completed_task;
    logic [3:0]  missed_mask;
    logic        queue_full;
    logic [31:0] waiting_sum;
    logic [31:0] jobs_created;
  } tick_result_t;

  typedef struct {
    bit [2:0]  owner;
    bit [31:0] due;
    bit [31:0] born;
    bit [15:0] left;
    bit [31:0] parked;
  } sched_job_t;

  // Scheduler shadow: its own copy of the task words, countdowns and job
  // queue; every accepted tick beat yields one expected result beat.
  class sched_scoreboard;
    bit [31:0]    task_word [4];
    bit [31:0]    now;
    bit [15:0]    countdown [4];
    int           depth_used;
    sched_job_t   jobs [SLOTS];
    bit [2:0]     running;
    bit [31:0]    wait_total;
    bit [31:0]    created;
    tick_result_t pending_ticks [$];
    int           errors;
    int           checked;
    int           fulls;
    int           misses;
    int           preempts;

    function bit [31:0] sat_sum(bit [31:0] a, bit [31:0] b);
      bit [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function bit precedes(sched_job_t a, sched_job_t b);
      if (a.due != b.due) return a.due < b.due;
      if (a.born != b.born) return a.born < b.born;
      return a.owner < b.owner;
    endfunction

    function bit release_job(int t);
      if (depth_used >= SLOTS) return 0;
      jobs[depth_used].owner  = 3'(t + 1);
      jobs[depth_used].due    = now + task_word[t][31:16];
      jobs[depth_used].born   = now;
      jobs[depth_used].left   = task_word[t][15:0];
      jobs[depth_used].parked = now;
      depth_used++;
      created = sat_sum(created, 1);
      return 1;
    endfunction

    function void note_tick(bit restart);
      tick_result_t r;
      bit [15:0]    p;
      int           best;
      sched_job_t   w;
      r = '0;
      if (restart) begin
        now = 0;
        depth_used = 0;
        running = 0;
        wait_total = 0;
        created = 0;
        for (int t = 0; t < 4; t++) countdown[t] = 0;
        for (int t = 0; t < 4; t++) begin
          p = task_word[t][31:16];
          if (p == 0) continue;
          countdown[t] = p;
          if (!release_job(t)) r.queue_full = 1;
        end
      end else begin
        now++;
        // retire an exhausted head job
        if (running != 0 && depth_used > 0 && jobs[0].left == 0) begin
          r.completed_task = running;
          for (int j = 1; j < depth_used; j++) jobs[j-1] = jobs[j];
          depth_used--;
          running = 0;
        end
        for (int t = 0; t < 4; t++) begin
          p = task_word[t][31:16];
          if (p == 0) continue;
          if (countdown[t] > 1) begin
            countdown[t]--;
            continue;
          end
          countdown[t] = p;
          for (int j = 0; j < depth_used; j++)
            if (jobs[j].owner == t + 1 && jobs[j].due == now) begin
              r.missed_mask[t] = 1;
              jobs[j].due = now + p;
            end
          if (!release_job(t)) r.queue_full = 1;
        end
      end
      if (depth_used == 0) begin
        running = 0;
      end else begin
        best = 0;
        for (int i = 1; i < depth_used; i++)
          if (precedes(jobs[i], jobs[best])) best = i;
        if (running == 0 || best != 0) begin
          if (running != 0) begin
            r.preempted_task = running;
            jobs[0].parked = now;
          end
          if (best != 0) begin
            w = jobs[best];
            for (int i = best; i > 0; i--) jobs[i] = jobs[i-1];
            jobs[0] = w;
          end
          r.started = 1;
          wait_total = sat_sum(wait_total, now - jobs[0].parked);
        end
        running = jobs[0].owner;
        if (jobs[0].left > 0) jobs[0].left--;
      end
      r.cur_time     = now;
      r.running_task = running;
      r.waiting_sum  = wait_total;
      r.jobs_created = created;
      if (r.queue_full) fulls++;
      if (r.missed_mask != 0) misses++;
      if (r.preempted_task != 0) preempts++;
      pending_ticks.push_back(r);
    endfunction

    function void check_tick(tick_result_t got);
      tick_result_t e;
      if (pending_ticks.size() == 0) begin
        $error("result beat with nothing expected (time %0d)", got.cur_time);
        errors++;
        return;
      end
      e = pending_ticks.pop_front();
      checked++;
      if (got.cur_time != e.cur_time) begin
        $error("current_time exp %0d got %0d", e.cur_time, got.cur_time); errors++;
      end
      if (got.running_task != e.running_task) begin
        $error("running_task exp %0d got %0d", e.running_task, got.running_task); errors++;
      end
      if (got.started != e.started) begin
        $error("started exp %0d got %0d", e.started, got.started); errors++;
      end
      if (got.preempted_task != e.preempted_task) begin
        $error("preempted_task exp %0d got %0d", e.preempted_task, got.preempted_task);
        errors++;
      end
      if (got.completed_task != e.completed_task) begin
        $error("completed_task exp %0d got %0d", e.completed_task, got.completed_task);
        errors++;
      end
      if (got.missed_mask != e.missed_mask) begin
        $error("missed_mask exp %h got %h", e.missed_mask, got.missed_mask); errors++;
      end
      if (got.queue_full != e.queue_full) begin
        $error("queue_full exp %0d got %0d", e.queue_full, got.queue_full); errors++;
      end
      if (got.waiting_sum != e.waiting_sum) begin
        $error("waiting_sum exp %0d got %0d", e.waiting_sum, got.waiting_sum); errors++;
      end
      if (got.jobs_created != e.jobs_created) begin
        $error("jobs_created exp %0d got %0d", e.jobs_created, got.jobs_created); errors++;
      end
    endfunction
  endclass

  logic                           clk = 0;
  logic                           rst_n = 0;
  logic                           cfg_we = 0;
  logic [edfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [edfs_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           in_valid = 0;
  logic                           in_ready;
  logic                           in_restart = 0;
  logic                           out_valid;
  logic                           out_ready = 0;
  logic [31:0]                    out_current_time;
  logic [2:0]                     out_running_task;
  logic                           out_started;
  logic [2:0]                     out_preempted_task;
  logic [2:0]                     out_completed_task;
  logic [3:0]                     out_missed_mask;
  logic                           out_queue_full;
  logic [31:0]                    out_waiting_sum;
  logic [31:0]                    out_jobs_created;
  tick_result_t                   got_beat;

  sched_scoreboard sb = new();
  int  cycles = 0;
  int  ticks_sent = 0;
  int  restarts_sent = 0;
  bit  no_idle = 0;   // phases with back-to-back beats on both sides

  always #10 clk = ~clk;

  edf_periodic_task_scheduler u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_restart         (in_restart),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_current_time   (out_current_time),
    .out_running_task   (out_running_task),
    .out_started        (out_started),
    .out_preempted_task (out_preempted_task),
    .out_completed_task (out_completed_task),
    .out_missed_mask    (out_missed_mask),
    .out_queue_full     (out_queue_full),
    .out_waiting_sum    (out_waiting_sum),
    .out_jobs_created   (out_jobs_created)
  );

  assign got_beat = {out_current_time, out_running_task, out_started, out_preempted_task,
                     out_completed_task, out_missed_mask, out_queue_full,
                     out_waiting_sum, out_jobs_created};

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d beats outstanding",
               cycles, sb.pending_ticks.size());
      $display("edf_periodic_task_scheduler regression: fail");
      $finish;
    end
  end

  // Result monitor: reads pre-edge values of the handshake
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_tick(got_beat);
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver back-pressure
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (no_idle || $urandom_range(0, 99) < 65) begin
        out_ready <= 1;
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          out_ready <= 0;
          repeat (hold) @(posedge clk);
        end
        out_ready <= 1;
      end
    end
  end

  // in_valid is lowered only when a gap follows, so back-to-back beats keep
  // it high with a single assignment per edge
  task automatic send_tick(bit restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(restart);
    ticks_sent++;
    if (restart) restarts_sent++;
  endtask

  // Stop sending, wait for every expected beat, then let the sequencer settle
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_ticks.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Block is idle here; writes one word per edge, shadow updated alongside
  task automatic load_tasks(logic [31:0] w0, logic [31:0] w1,
                            logic [31:0] w2, logic [31:0] w3);
    logic [31:0] words [4];
    words = '{w0, w1, w2, w3};
    for (int i = TASK_WORD_0; i <= TASK_WORD_3; i++) begin
      cfg_we    <= 1;
      cfg_index <= edfs_pkg::CFG_IDX_W'(i);
      cfg_data  <= words[i];
      @(posedge clk);
      sb.task_word[i] = words[i];
    end
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] random_task_word();
    int r;
    logic [15:0] period, budget;
    r = $urandom_range(0, 99);
    if (r < 12) period = 0;
    else if (r < 20) period = 16'($urandom);
    else period = 16'($urandom_range(1, 12));
    budget = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    return {period, budget};
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Ticks before any restart: every enabled task releases at time 1
    load_tasks({16'd3, 16'd1}, 32'hFFFF_FFFF, 32'h0000_0000, {16'd2, 16'd0});
    repeat (3) send_tick(0);
    // Restart with a zero-budget task and a disabled one
    send_tick(1);
    repeat (5) send_tick(0);
    drain();

    // Period 1, mostly huge budgets: queue fills and overflows, misses on every tick after the restart
    load_tasks({16'd1, 16'hFFFF}, {16'd1, 16'hFFFF}, {16'd1, 16'h8000}, {16'd1, 16'h0001});
    send_tick(1);
    repeat (7) send_tick(0);
    drain();

    // Register change without restart: takes effect at the next release
    load_tasks({16'd2, 16'd1}, {16'd5, 16'd2}, {16'd7, 16'd3}, 32'h0000_FFFF);
    repeat (6) send_tick(0);
    drain();

    // Random phases
    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph == 2 || ph == 5);
      load_tasks(random_task_word(), random_task_word(),
                 random_task_word(), random_task_word());
      if (ph != 3) send_tick(1);
      for (int n = 0; n < 85; n++) begin
        // hold off until all results have been returned
        if (n == 40 && ph % 2 == 0) drain();
        send_tick($urandom_range(0, 99) < 3);
      end
      drain();
    end

    $display("checked %0d tick results from %0d beats (%0d restarts)",
             sb.checked, ticks_sent, restarts_sent);
    $display("ticks with overflow %0d, with misses %0d, with preemption %0d",
             sb.fulls, sb.misses, sb.preempts);
    if (sb.errors == 0 && sb.pending_ticks.size() == 0) begin
      $display("edf_periodic_task_scheduler regression: pass");
    end else begin
      $display("edf_periodic_task_scheduler regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/edfs_pkg.sv
hdl/edfs_job_ram.sv
hdl/edf_periodic_task_scheduler.sv
tb/sv/edf_periodic_task_scheduler_test.sv
